@@ hw/rtl/spru_pkg.sv @@
package spru_pkg;

    localparam int ELEM_W = 4;
    localparam int RANK_W = 63;
    localparam int LEN_W  = 5;
    localparam int CNT_W  = 64;

    // Function select on the input beat.
    localparam logic FUNC_RANK   = 1'b0;
    localparam logic FUNC_UNRANK = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_ELEM = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] result;
        logic             borrow;
    } alu_res_t;

    typedef struct packed {
        logic              func;
        logic [ELEM_W-1:0] element_in;
        logic [RANK_W-1:0] rank_in;
        logic              last_in;
    } spru_in_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank_out;
        logic [ELEM_W-1:0] element_out;
        logic              last_out;
        logic [1:0]        status;
    } spru_out_t;

endpackage

@@ hw/rtl/set_partition_rank_unrank_unit.sv @@
// Set partition rank/unrank unit: lexicographic ranking of restricted growth
// strings of length n (the cfg register, saturated into 1..MAX_LENGTH).
// Input channel s_*: with func = rank, each beat carries one element; after
// the beat with last_in set, or the n-th element, one result beat gives the
// rank (status 1 and rank 0 if an element broke the growth rule or the
// sequence was short). With func = unrank, one beat carries a rank and the
// unit returns n result beats, one element each, the final one marked; a
// rank at or above the Bell number gives a single beat with status 2.
// Order of work: a rank element is taken in idle, then gets one adder pass
// per unit of the element value, then the end step; the element that closes
// a sequence then loads its result beat in the emit state. An unrank beat
// gets the range check, then a table read and a compare for each candidate
// value tested at each position, and an emit step per result beat. All of
// it runs through one shared 64-bit add/subtract/multiply unit and one
// table read port. After reset, and after each cfg write, the completion
// table is rebuilt, with s_ready low. The result sits in an output register;
// a stalled receiver holds the sequencer only when it has the next result
// ready, and a new input beat is taken as soon as the sequencer is idle even
// while a result waits.
module set_partition_rank_unrank_unit #(
    parameter int MAX_LENGTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  spru_pkg::spru_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output spru_pkg::spru_out_t        m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [spru_pkg::LEN_W-1:0] cfg_data
);

    // LW holds a length or position up to MAX_LENGTH; KW indexes a table row
    // or column, which never reaches MAX_LENGTH.
    localparam int LW        = $clog2(MAX_LENGTH + 1);
    localparam int KW        = $clog2(MAX_LENGTH);
    localparam int AW        = 2 * KW;
    localparam int SW        = LW + 1;
    localparam int CW        = ((LW > spru_pkg::ELEM_W) ? LW : spru_pkg::ELEM_W) + 1;
    localparam int RESET_LEN = (MAX_LENGTH < 4) ? MAX_LENGTH : 4;

    typedef enum logic [10:0] {
        ST_BUILD_INIT = 11'b000_0000_0001,
        ST_BUILD_RDA  = 11'b000_0000_0010,
        ST_BUILD_RDB  = 11'b000_0000_0100,
        ST_BUILD_WR   = 11'b000_0000_1000,
        ST_IDLE       = 11'b000_0001_0000,
        ST_RANK_ADD   = 11'b000_0010_0000,
        ST_RANK_END   = 11'b000_0100_0000,
        ST_UNR_CHK    = 11'b000_1000_0000,
        ST_UNR_RD     = 11'b001_0000_0000,
        ST_UNR_CMP    = 11'b010_0000_0000,
        ST_EMIT       = 11'b100_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [LW-1:0]                 len_reg, len_next;
    // pos_reg/q_reg serve as row/column counters while the table is built,
    // as position/candidate while a sequence is processed.
    logic [LW-1:0]                 pos_reg, pos_next;
    logic [LW-1:0]                 q_reg, q_next;
    logic [LW-1:0]                 rm_reg, rm_next;
    logic [spru_pkg::CNT_W-1:0]    acc_reg, acc_next;
    logic                          err_reg, err_next;
    logic [spru_pkg::CNT_W-1:0]    prod_reg, prod_next;
    logic [spru_pkg::ELEM_W-1:0]   elem_reg, elem_next;
    logic                          last_reg, last_next;
    spru_pkg::spru_out_t           res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    spru_pkg::spru_out_t           m_data_reg, m_data_next;

    logic [LW-1:0]                 len_m1;
    logic [LW-1:0]                 k_cur;
    logic [LW-1:0]                 q_inc;
    logic [LW-1:0]                 pos_inc;
    logic [LW-1:0]                 rm_inc;
    logic [LW-1:0]                 q_max;
    logic [LW-1:0]                 cfg_len;
    logic                          out_free;
    logic                          s_fire;
    logic                          elem_gt;
    logic                          rank_bad;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [spru_pkg::CNT_W-1:0]    wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [spru_pkg::CNT_W-1:0]    rd_data;

    spru_pkg::alu_op_t             alu_op;
    logic [spru_pkg::CNT_W-1:0]    alu_a;
    logic [spru_pkg::CNT_W-1:0]    alu_b;
    spru_pkg::alu_res_t            alu_res;

    // Completion-count table, row k = positions still to fill, column m =
    // running maximum. Only reachable entries (m + k < n) are written, and
    // only those are ever read.
    spru_table #(
        .AW(AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spru_alu #(
        .FW(LW)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign len_m1   = len_reg - LW'(1);
    assign k_cur    = len_m1 - pos_reg;
    assign q_inc    = q_reg + LW'(1);
    assign pos_inc  = pos_reg + LW'(1);
    assign rm_inc   = rm_reg + LW'(1);
    assign q_max    = (q_reg > rm_reg) ? q_reg : rm_reg;
    assign out_free = !m_valid_reg || m_ready;

    // A cfg write wins over an input beat offered in the same cycle.
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;

    // An element more than one above the running maximum breaks the rule.
    assign elem_gt  = CW'(s_data.element_in) > (CW'(rm_reg) + CW'(1));
    assign rank_bad = err_reg || (pos_inc < len_reg);

    always_comb begin
        if (cfg_data == '0) begin
            cfg_len = LW'(1);
        end else if (cfg_data > spru_pkg::LEN_W'(MAX_LENGTH)) begin
            cfg_len = LW'(MAX_LENGTH);
        end else begin
            cfg_len = LW'(cfg_data);
        end
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        q_next       = q_reg;
        rm_next      = rm_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        prod_next    = prod_reg;
        elem_next    = elem_reg;
        last_next    = last_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        alu_op  = spru_pkg::ALU_ADD;
        alu_a   = acc_reg;
        alu_b   = rd_data;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Row 0 of the table is all ones.
            ST_BUILD_INIT: begin
                wr_en   = 1'b1;
                wr_addr = {KW'(0), KW'(q_reg)};
                wr_data = spru_pkg::CNT_W'(1);
                q_next  = q_inc;
                if (q_inc == len_reg) begin
                    q_next = '0;
                    if (len_reg == LW'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = LW'(1);
                        state_next = ST_BUILD_RDA;
                    end
                end
            end
            ST_BUILD_RDA: begin
                rd_en      = 1'b1;
                rd_addr    = {KW'(pos_reg - LW'(1)), KW'(q_reg)};
                state_next = ST_BUILD_RDB;
            end
            // T[k-1][m] is back: scale it by m+1 while T[k-1][m+1] is read.
            ST_BUILD_RDB: begin
                rd_en      = 1'b1;
                rd_addr    = {KW'(pos_reg - LW'(1)), KW'(q_inc)};
                alu_op     = spru_pkg::ALU_MUL;
                alu_a      = rd_data;
                alu_b      = spru_pkg::CNT_W'(q_inc);
                prod_next  = alu_res.result;
                state_next = ST_BUILD_WR;
            end
            ST_BUILD_WR: begin
                alu_op  = spru_pkg::ALU_ADD;
                alu_a   = prod_reg;
                alu_b   = rd_data;
                wr_en   = 1'b1;
                wr_addr = {KW'(pos_reg), KW'(q_reg)};
                wr_data = alu_res.result;
                if ((SW'(q_inc) + SW'(pos_reg)) < SW'(len_reg)) begin
                    q_next     = q_inc;
                    state_next = ST_BUILD_RDA;
                end else if (pos_inc < len_reg) begin
                    pos_next   = pos_inc;
                    q_next     = '0;
                    state_next = ST_BUILD_RDA;
                end else begin
                    pos_next   = '0;
                    q_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cfg_valid) begin
                    len_next   = cfg_len;
                    pos_next   = '0;
                    q_next     = '0;
                    rm_next    = '0;
                    acc_next   = '0;
                    err_next   = 1'b0;
                    state_next = ST_BUILD_INIT;
                end else if (s_fire) begin
                    rd_en  = 1'b1;
                    q_next = '0;
                    if (s_data.func == spru_pkg::FUNC_UNRANK) begin
                        // Fetch the Bell number for the range check.
                        rd_addr    = {KW'(len_m1), KW'(0)};
                        acc_next   = {1'b0, s_data.rank_in};
                        pos_next   = '0;
                        rm_next    = '0;
                        err_next   = 1'b0;
                        state_next = ST_UNR_CHK;
                    end else begin
                        // Every smaller candidate adds T[k][running max].
                        rd_addr   = {KW'(k_cur), KW'(rm_reg)};
                        elem_next = s_data.element_in;
                        last_next = s_data.last_in;
                        if (pos_reg == '0) begin
                            if (s_data.element_in != '0) begin
                                err_next = 1'b1;
                            end
                            state_next = ST_RANK_END;
                        end else if (elem_gt) begin
                            err_next   = 1'b1;
                            state_next = ST_RANK_END;
                        end else begin
                            if (CW'(s_data.element_in) > CW'(rm_reg)) begin
                                rm_next = LW'(s_data.element_in);
                            end
                            if (s_data.element_in == '0) begin
                                state_next = ST_RANK_END;
                            end else begin
                                state_next = ST_RANK_ADD;
                            end
                        end
                    end
                end
            end
            ST_RANK_ADD: begin
                alu_op   = spru_pkg::ALU_ADD;
                acc_next = alu_res.result;
                q_next   = q_inc;
                if (CW'(q_inc) == CW'(elem_reg)) begin
                    state_next = ST_RANK_END;
                end
            end
            ST_RANK_END: begin
                pos_next = pos_inc;
                if (!last_reg && (pos_inc < len_reg)) begin
                    state_next = ST_IDLE;
                end else begin
                    res_next.rank_out    = rank_bad ? '0 : acc_reg[spru_pkg::RANK_W-1:0];
                    res_next.element_out = '0;
                    res_next.last_out    = 1'b1;
                    res_next.status      = rank_bad ? spru_pkg::STATUS_BAD_ELEM
                                                    : spru_pkg::STATUS_OK;
                    state_next           = ST_EMIT;
                end
            end
            ST_UNR_CHK: begin
                alu_op               = spru_pkg::ALU_SUB;
                res_next.rank_out    = '0;
                res_next.element_out = '0;
                if (!alu_res.borrow) begin
                    res_next.last_out = 1'b1;
                    res_next.status   = spru_pkg::STATUS_RANGE;
                end else begin
                    // The first element is always zero.
                    res_next.last_out = (len_reg == LW'(1));
                    res_next.status   = spru_pkg::STATUS_OK;
                    pos_next          = LW'(1);
                    q_next            = '0;
                end
                state_next = ST_EMIT;
            end
            ST_UNR_RD: begin
                rd_en      = 1'b1;
                rd_addr    = {KW'(k_cur), KW'(q_max)};
                state_next = ST_UNR_CMP;
            end
            // Walk the candidates in order; the rank falls inside the first
            // block whose count exceeds what is left. The top candidate is
            // taken when all smaller ones are used up.
            ST_UNR_CMP: begin
                alu_op = spru_pkg::ALU_SUB;
                if (!alu_res.borrow) begin
                    acc_next = alu_res.result;
                end
                if (alu_res.borrow || (q_reg == rm_inc)) begin
                    res_next.rank_out    = '0;
                    res_next.element_out = spru_pkg::ELEM_W'(q_reg);
                    res_next.last_out    = (pos_reg == len_m1);
                    res_next.status      = spru_pkg::STATUS_OK;
                    if (q_reg > rm_reg) begin
                        rm_next = q_reg;
                    end
                    pos_next   = pos_inc;
                    q_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    q_next     = q_inc;
                    state_next = ST_UNR_RD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    if (res_reg.last_out) begin
                        pos_next   = '0;
                        q_next     = '0;
                        rm_next    = '0;
                        acc_next   = '0;
                        err_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_UNR_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_BUILD_INIT;
            len_reg     <= LW'(RESET_LEN);
            pos_reg     <= '0;
            q_reg       <= '0;
            rm_reg      <= '0;
            acc_reg     <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            q_reg       <= q_next;
            rm_reg      <= rm_next;
            acc_reg     <= acc_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hw/rtl/spru_table.sv @@
module spru_table #(
    parameter int AW = 8
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [spru_pkg::CNT_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [spru_pkg::CNT_W-1:0] rd_data
);

    logic [spru_pkg::CNT_W-1:0] mem_reg [0:(1<<AW)-1];
    logic [spru_pkg::CNT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/spru_alu.sv @@
module spru_alu #(
    parameter int FW = 5
) (
    input  spru_pkg::alu_op_t          op,
    input  logic [spru_pkg::CNT_W-1:0] a,
    input  logic [spru_pkg::CNT_W-1:0] b,
    output spru_pkg::alu_res_t         res
);

    logic [spru_pkg::CNT_W:0]      diff;
    logic [spru_pkg::CNT_W+FW-1:0] prod;

    // The multiply takes only a small factor from the low bits of b.
    always_comb begin
        diff = {1'b0, a} - {1'b0, b};
        prod = a * b[FW-1:0];
        res  = '0;
        unique case (op)
            spru_pkg::ALU_ADD: begin
                res.result = a + b;
            end
            spru_pkg::ALU_SUB: begin
                res.result = diff[spru_pkg::CNT_W-1:0];
                res.borrow = diff[spru_pkg::CNT_W];
            end
            spru_pkg::ALU_MUL: begin
                res.result = prod[spru_pkg::CNT_W-1:0];
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/spru_checker.sv @@
module spru_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input spru_pkg::spru_in_t         s_data,
    input logic                       m_valid,
    input logic                       m_ready,
    input spru_pkg::spru_out_t        m_data,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [spru_pkg::LEN_W-1:0] cfg_data
);

    // A result beat waiting on the receiver must hold still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Out of range is a single, final beat.
    a_range_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == spru_pkg::STATUS_RANGE) |->
            m_data.last_out && (m_data.element_out == '0) && (m_data.rank_out == '0))
        else $error("range error beat malformed");

    // A flagged result never carries a rank.
    a_bad_no_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != spru_pkg::STATUS_OK) |-> (m_data.rank_out == '0))
        else $error("flagged result carries a rank");

    // A pending register write blocks the input channel.
    a_cfg_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> !s_ready)
        else $error("input accepted alongside a cfg write");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind set_partition_rank_unrank_unit spru_checker u_spru_checker (.*);
